// ----- rtl/pcpc_pkg.sv -----
// Shared types and constants of the pedal control panel conditioner.
package pcpc_pkg;

	localparam int unsigned NUM_POTS    = 3;
	localparam int unsigned NUM_EFFECTS = 3;
	localparam int unsigned POT_W       = 8;
	localparam int unsigned BTN_LEVEL_W = 4;

	// Pot lane order inside the pot arrays
	localparam int unsigned POT_VOLUME = 0;
	localparam int unsigned POT_TONE   = 1;
	localparam int unsigned POT_GAIN   = 2;

	// Effect numbers
	localparam logic [1:0] EFFECT_FIRST  = 2'd0;
	localparam logic [1:0] EFFECT_SECOND = 2'd1;
	localparam logic [1:0] EFFECT_THIRD  = 2'd2;

	localparam logic [POT_W-1:0] MAX_POT_RESET = 8'd255;

	typedef struct packed {
		logic             select_first;
		logic             select_second;
		logic             toggle_pin;
		logic [POT_W-1:0] volume_sample;
		logic [POT_W-1:0] tone_sample;
		logic [POT_W-1:0] gain_sample;
	} in_item_t;

	typedef struct packed {
		logic [NUM_EFFECTS-1:0] active_mask;
		logic                   send_now;
		logic [1:0]             effect_index;
		logic [POT_W-1:0]       volume_out;
		logic [POT_W-1:0]       tone_out;
		logic [POT_W-1:0]       gain_out;
		logic [POT_W-1:0]       inverse_volume_out;
	} out_item_t;

	// Status handed from the lanes to the merging stage
	typedef struct packed {
		logic                select_first;
		logic                select_second;
		logic                button_fall;
		logic [NUM_POTS-1:0] pot_changed;
	} lane_status_t;

endpackage

// ----- rtl/pcpc_window_lane.sv -----
// Moving-window lane: running sum over the last WIN samples, shifted level out.
module pcpc_window_lane #(
	parameter int unsigned WIN   = 8,
	parameter int unsigned SHIFT = 3,
	parameter int unsigned DW    = 8,
	parameter int unsigned OW    = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic [DW-1:0] sample,
	output logic [OW-1:0] level,
	output logic          changed
);

	localparam int unsigned SUM_W  = $clog2(WIN * ((1 << DW) - 1) + 1);
	localparam int unsigned SLOT_W = (WIN > 1) ? $clog2(WIN) : 1;
	localparam int unsigned EXT_W  = SUM_W + OW;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WIN - 1);

	logic [DW-1:0]    hist_mem [WIN];
	logic [DW-1:0]    rd_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] slot_n;
	logic             wrapped_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] sum_n;
	logic [DW-1:0]    oldest;
	logic [EXT_W-1:0] ext_q;
	logic [EXT_W-1:0] ext_n;

	// an entry never written yet is taken as zero until the window has wrapped
	assign oldest = wrapped_q ? rd_q : '0;
	assign slot_n = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
	assign sum_n  = sum_q - SUM_W'(oldest) + SUM_W'(sample);
	assign ext_q  = {{OW{1'b0}}, sum_q} >> SHIFT;
	assign ext_n  = {{OW{1'b0}}, sum_n} >> SHIFT;
	assign level   = ext_n[OW-1:0];
	assign changed = ext_n[OW-1:0] != ext_q[OW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
		end else if (advance) begin
			slot_q    <= slot_n;
			wrapped_q <= wrapped_q | (slot_q == LAST_SLOT);
			sum_q     <= sum_n;
		end
	end

	// write the new sample, prefetch the entry that leaves the window next
	always_ff @(posedge clk) begin
		if (advance) begin
			hist_mem[slot_q] <= sample;
			rd_q <= (slot_n == slot_q) ? sample : hist_mem[slot_n];
		end
	end

endmodule

// ----- rtl/pcpc_merge.sv -----
// Merging stage: effect selection, toggle flags, send decision and result item.
module pcpc_merge (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 advance,
	input  pcpc_pkg::lane_status_t               status,
	input  logic [pcpc_pkg::POT_W-1:0]           pot_level [pcpc_pkg::NUM_POTS],
	input  logic [pcpc_pkg::POT_W-1:0]           max_level,
	output pcpc_pkg::out_item_t                  result
);

	logic [pcpc_pkg::NUM_EFFECTS-1:0] active_q;
	logic [pcpc_pkg::NUM_EFFECTS-1:0] active_n;
	logic [pcpc_pkg::NUM_EFFECTS-1:0] sel_hot;
	logic                             pending_q;
	logic                             pending_eff;
	logic                             send;
	logic [1:0]                       sel;
	logic [pcpc_pkg::POT_W-1:0]       vol;

	always_comb begin
		if (status.select_first) begin
			sel = pcpc_pkg::EFFECT_FIRST;
		end else if (status.select_second) begin
			sel = pcpc_pkg::EFFECT_SECOND;
		end else begin
			sel = pcpc_pkg::EFFECT_THIRD;
		end
		case (sel)
			pcpc_pkg::EFFECT_FIRST:  sel_hot = 3'b001;
			pcpc_pkg::EFFECT_SECOND: sel_hot = 3'b010;
			default:                 sel_hot = 3'b100;
		endcase
	end

	assign vol         = pot_level[pcpc_pkg::POT_VOLUME];
	assign active_n    = status.button_fall ? (active_q ^ sel_hot) : active_q;
	assign pending_eff = pending_q | status.button_fall;
	assign send        = |(active_n & sel_hot) & ((|status.pot_changed) | pending_eff);

	always_comb begin
		result              = '0;
		result.active_mask  = active_n;
		result.send_now     = send;
		result.effect_index = sel;
		if (send) begin
			result.volume_out         = vol;
			result.tone_out           = pot_level[pcpc_pkg::POT_TONE];
			result.gain_out           = pot_level[pcpc_pkg::POT_GAIN];
			result.inverse_volume_out = (max_level > vol) ? max_level - vol : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			pending_q <= 1'b0;
		end else if (advance) begin
			active_q  <= active_n;
			pending_q <= pending_eff & ~send;
		end
	end

endmodule

// ----- rtl/pedal_control_panel_conditioner.sv -----
// Top level of the pedal control panel conditioner: lanes, merge and output skid.
//
//  channel | direction | payload              | handshake
//  --------+-----------+----------------------+---------------------
//  in      | input     | in_data  (in_item_t) | in_valid / in_stall
//  out     | output    | out_data (out_item_t)| out_valid / out_stall
//  cfg     | input     | cfg_wdata (8 bit)    | cfg_we, no wait
//
// One request per cycle while in_stall is low: each lane updates its sum in the
// accept cycle and the result is registered in out_q, or in skid_q if held.
// The rate is set by the single add-subtract of each lane's running sum.
// Reset clears windows (by a per-lane wrap flag), flags and both output
// stages; max_level_q returns to full scale.
// A stalled output parks the next result in a skid register; in_stall rises
// only when that skid register is full.
module pedal_control_panel_conditioner #(
	parameter int unsigned POT_WINDOW    = 8,
	parameter int unsigned POT_SHIFT     = 3,
	parameter int unsigned BUTTON_WINDOW = 8,
	parameter int unsigned BUTTON_SHIFT  = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  pcpc_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output pcpc_pkg::out_item_t        out_data,
	input  logic                       cfg_we,
	input  logic [pcpc_pkg::POT_W-1:0] cfg_wdata
);

	logic                             accept;
	logic                             take;
	logic [pcpc_pkg::POT_W-1:0]       max_level_q;
	logic [pcpc_pkg::POT_W-1:0]       pot_sample [pcpc_pkg::NUM_POTS];
	logic [pcpc_pkg::POT_W-1:0]       pot_level  [pcpc_pkg::NUM_POTS];
	logic [pcpc_pkg::NUM_POTS-1:0]    pot_changed;
	logic [pcpc_pkg::BTN_LEVEL_W-1:0] btn_level;
	logic                             btn_changed;
	pcpc_pkg::lane_status_t           status;
	pcpc_pkg::out_item_t              result;
	pcpc_pkg::out_item_t              out_q;
	pcpc_pkg::out_item_t              skid_q;
	logic                             out_valid_q;
	logic                             skid_valid_q;

	assign in_stall  = skid_valid_q;
	assign accept    = in_valid & ~skid_valid_q;
	assign take      = out_valid_q & ~out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// hold the full-scale pot code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_level_q <= pcpc_pkg::MAX_POT_RESET;
		end else if (cfg_we) begin
			max_level_q <= cfg_wdata;
		end
	end

	assign pot_sample[pcpc_pkg::POT_VOLUME] = in_data.volume_sample;
	assign pot_sample[pcpc_pkg::POT_TONE]   = in_data.tone_sample;
	assign pot_sample[pcpc_pkg::POT_GAIN]   = in_data.gain_sample;

	// one smoothing lane per pot, all advancing together
	for (genvar p = 0; p < pcpc_pkg::NUM_POTS; p++) begin : g_pot
		pcpc_window_lane #(
			.WIN   (POT_WINDOW),
			.SHIFT (POT_SHIFT),
			.DW    (pcpc_pkg::POT_W),
			.OW    (pcpc_pkg::POT_W)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (accept),
			.sample  (pot_sample[p]),
			.level   (pot_level[p]),
			.changed (pot_changed[p])
		);
	end

	// debounce lane for the toggle button
	pcpc_window_lane #(
		.WIN   (BUTTON_WINDOW),
		.SHIFT (BUTTON_SHIFT),
		.DW    (1),
		.OW    (pcpc_pkg::BTN_LEVEL_W)
	) u_button (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.sample  (in_data.toggle_pin),
		.level   (btn_level),
		.changed (btn_changed)
	);

	always_comb begin
		status.select_first  = in_data.select_first;
		status.select_second = in_data.select_second;
		status.button_fall   = btn_changed & (btn_level == '0);
		status.pot_changed   = pot_changed;
	end

	pcpc_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (accept),
		.status    (status),
		.pot_level (pot_level),
		.max_level (max_level_q),
		.result    (result)
	);

	// output register with skid: drain skid first, else fill output or park
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (out_valid_q && !take) begin
				skid_q <= result;
			end else begin
				out_q <= result;
			end
		end
	end

endmodule

// ----- rtl/pcpc_checker.sv -----
// Port-level checker for the pedal control panel conditioner and its bind.
module pcpc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input pcpc_pkg::in_item_t         in_data,
	input logic                       out_valid,
	input logic                       out_stall,
	input pcpc_pkg::out_item_t        out_data
);

	// input side backs up only behind a waiting result
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("in_stall without a pending result");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// without a send the pot values read as zero
	a_quiet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.send_now |->
			out_data.volume_out == '0 && out_data.tone_out == '0 &&
			out_data.gain_out == '0 && out_data.inverse_volume_out == '0)
		else $error("values shown without a send");

	// a send only comes from an active selected effect
	a_send_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.send_now |->
			(out_data.effect_index == pcpc_pkg::EFFECT_FIRST && out_data.active_mask[0]) ||
			(out_data.effect_index == pcpc_pkg::EFFECT_SECOND && out_data.active_mask[1]) ||
			(out_data.effect_index == pcpc_pkg::EFFECT_THIRD && out_data.active_mask[2]))
		else $error("send for an inactive effect");

endmodule

bind pedal_control_panel_conditioner pcpc_checker u_pcpc_checker (.*);
